// ===== rtl/cci_pkg.sv =====
package cci_pkg;

    // line buffer geometry
    localparam int LINE_MAX = 32;
    localparam int LEN_W    = $clog2(LINE_MAX + 1);
    localparam int ADDR_W   = $clog2(LINE_MAX);

    // reply templates
    localparam int TPL_MAX = 38;
    localparam int POS_W   = $clog2(TPL_MAX);

    // binary to BCD converter: 32-bit value into 11 digits
    localparam int VAL_W      = 32;
    localparam int BCD_DIGITS = 11;
    localparam int BCD_W      = 4 * BCD_DIGITS;
    localparam int CONV_STEPS = VAL_W;
    localparam int CNT_W      = $clog2(CONV_STEPS);

    // x/63 as (x*16645)>>20, exact for x below 16128
    localparam logic [14:0] AG_RECIP  = 15'd16645;
    // y/255 as (y*65794)>>24, exact for y below 16384
    localparam logic [16:0] SET_RECIP = 17'd65794;

    // result kinds
    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_SET  = 2'd1;
    localparam logic [1:0] KIND_DROP = 2'd2;

    // set request targets
    localparam logic [1:0] SK_FREQ = 2'd0;
    localparam logic [1:0] SK_MODE = 2'd1;
    localparam logic [1:0] SK_VOL  = 2'd2;
    localparam logic [1:0] SK_MUTE = 2'd3;

    // characters
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_1     = 8'h31;
    localparam logic [7:0] CH_2     = 8'h32;
    localparam logic [7:0] CH_3     = 8'h33;
    localparam logic [7:0] CH_4     = 8'h34;
    localparam logic [7:0] CH_5     = 8'h35;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_Z     = 8'h5A;

    // template placeholders, never part of a reply
    localparam logic [7:0] PH_DIG0  = 8'h61;  // 'a': BCD digit 0 .. 'k': digit 10
    localparam logic [7:0] PH_DIG10 = 8'h6B;
    localparam logic [7:0] PH_C0    = 8'h23;  // '#': first command letter
    localparam logic [7:0] PH_C1    = 8'h24;  // '$': second command letter
    localparam logic [7:0] PH_A0    = 8'h25;  // '%': first argument char
    localparam logic [7:0] PH_MODE  = 8'h26;  // '&': mode digit
    localparam logic [7:0] PH_MUTE  = 8'h2A;  // '*': mute digit

    // command names
    localparam logic [15:0] CMD_ID = "ID";
    localparam logic [15:0] CMD_PS = "PS";
    localparam logic [15:0] CMD_AI = "AI";
    localparam logic [15:0] CMD_FA = "FA";
    localparam logic [15:0] CMD_FB = "FB";
    localparam logic [15:0] CMD_FR = "FR";
    localparam logic [15:0] CMD_FT = "FT";
    localparam logic [15:0] CMD_MD = "MD";
    localparam logic [15:0] CMD_SM = "SM";
    localparam logic [15:0] CMD_AG = "AG";
    localparam logic [15:0] CMD_SQ = "SQ";
    localparam logic [15:0] CMD_MU = "MU";
    localparam logic [15:0] CMD_IF = "IF";
    localparam logic [15:0] CMD_ZZ = "ZZ";
    localparam logic [15:0] CMD_RX = "RX";
    localparam logic [15:0] CMD_TX = "TX";

    typedef enum logic [3:0] {
        TPL_Q, TPL_ID, TPL_PS, TPL_SQ, TPL_N, TPL_O, TPL_AI, TPL_F11,
        TPL_FR, TPL_MD, TPL_SM, TPL_SMA, TPL_AG, TPL_AGA, TPL_MU, TPL_IF
    } t_tpl;

    typedef enum logic [2:0] {
        VS_NONE, VS_AIM, VS_FREQ, VS_VFO, VS_METER, VS_AGV
    } t_vsrc;

    typedef enum logic [1:0] {SS_ACC, SS_MODE, SS_AG, SS_MUTE} t_ssrc;

    typedef enum logic [1:0] {CLS_SKIP, CLS_SEMI, CLS_LEGAL, CLS_ILLEGAL} t_cls;

    typedef struct packed {
        logic       reply;
        t_tpl       tpl;
        t_vsrc      vsrc;
        logic       parse;
        logic       pstart3;
        logic       set;
        t_ssrc      ssrc;
        logic [1:0] set_kind;
        logic       vfo_parse;
        logic       drop;
        logic       aim_wr;
        logic       vfo_snap;
        logic       cw_wr;
    } t_plan;

    typedef struct packed {
        logic  snap_ld;
        logic  buf_wr;
        logic  drop_line;
        logic  disc_clr;
        logic  run_start;
        logic  aim_wr;
        logic  vfo_snap;
        logic  cw_wr;
        logic  parse_init;
        logic  parse_rd;
        logic  parse_acc;
        logic  calc;
        logic  conv_step;
        logic  pos_clr;
        logic  emit_tpl;
        logic  emit_one;
        t_plan plan;
    } t_dp_cmd;

    typedef struct packed {
        t_cls             cls;
        logic             discarding;
        logic             len_zero;
        logic             len_full;
        logic [7:0]       c0;
        logic [7:0]       c1;
        logic [7:0]       a0;
        logic [LEN_W-1:0] run_len;
        logic             vfo_zero;
        logic             rd_digit;
        logic             parse_end;
        logic             conv_last;
        logic             emit_last;
        logic             out_free;
    } t_dp_sts;

    function automatic logic [POS_W-1:0] tpl_len(t_tpl t);
        logic [POS_W-1:0] l;
        case (t)
            TPL_Q:   l = POS_W'(2);
            TPL_ID:  l = POS_W'(6);
            TPL_PS:  l = POS_W'(4);
            TPL_SQ:  l = POS_W'(7);
            TPL_N:   l = POS_W'(2);
            TPL_O:   l = POS_W'(2);
            TPL_AI:  l = POS_W'(4);
            TPL_F11: l = POS_W'(14);
            TPL_FR:  l = POS_W'(4);
            TPL_MD:  l = POS_W'(4);
            TPL_SM:  l = POS_W'(7);
            TPL_SMA: l = POS_W'(8);
            TPL_AG:  l = POS_W'(6);
            TPL_AGA: l = POS_W'(7);
            TPL_MU:  l = POS_W'(4);
            TPL_IF:  l = POS_W'(38);
            default: l = POS_W'(2);
        endcase
        return l;
    endfunction

    // right-aligned text, last character in the low byte
    function automatic logic [8*TPL_MAX-1:0] tpl_text(t_tpl t);
        logic [8*TPL_MAX-1:0] s;
        s = '0;
        case (t)
            TPL_Q:   s[15:0]  = "?;";
            TPL_ID:  s[47:0]  = "ID020;";
            TPL_PS:  s[31:0]  = "PS1;";
            TPL_SQ:  s[55:0]  = "SQ0000;";
            TPL_N:   s[15:0]  = "N;";
            TPL_O:   s[15:0]  = "O;";
            TPL_AI:  s[31:0]  = "#$a;";
            TPL_F11: s[111:0] = "#$kjihgfedcba;";
            TPL_FR:  s[31:0]  = "#$0;";
            TPL_MD:  s[31:0]  = "#$&;";
            TPL_SM:  s[55:0]  = "#$dcba;";
            TPL_SMA: s[63:0]  = "#$%dcba;";
            TPL_AG:  s[47:0]  = "#$cba;";
            TPL_AGA: s[55:0]  = "#$%cba;";
            TPL_MU:  s[31:0]  = "#$*;";
            TPL_IF:  s = "#$kjihgfedcba0000+00000000000&0000000;";
            default: s[15:0]  = "?;";
        endcase
        return s;
    endfunction

endpackage

// ===== rtl/cci_in_if.sv =====
interface cci_in_if;
    logic              valid;
    logic              ready;
    logic              cmd;
    logic [7:0]        rx_byte;
    logic [31:0]       freq_hz;
    logic [1:0]        radio_mode;
    logic [5:0]        volume;
    logic signed [7:0] rssi_dbuv;
    logic              muted;

    modport source (output valid, cmd, rx_byte, freq_hz, radio_mode, volume, rssi_dbuv,
                    muted, input ready);
    modport sink   (input valid, cmd, rx_byte, freq_hz, radio_mode, volume, rssi_dbuv,
                    muted, output ready);
endinterface

// ===== rtl/cci_out_if.sv =====
interface cci_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  out_byte;
    logic [1:0]  set_kind;
    logic [31:0] set_value;
    logic        last;

    modport source (output valid, kind, out_byte, set_kind, set_value, last, input ready);
    modport sink   (input valid, kind, out_byte, set_kind, set_value, last, output ready);
endinterface

// ===== rtl/cci_ram.sv =====
module cci_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/cci_ctrl.sv =====
module cci_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_cmd,
    output logic              o_in_ready,
    input  cci_pkg::t_dp_sts  i_sts,
    output cci_pkg::t_dp_cmd  o_cmd
);
    import cci_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_EXEC = 8'b0000_0010,
        S_PRD  = 8'b0000_0100,
        S_PACC = 8'b0000_1000,
        S_CALC = 8'b0001_0000,
        S_CONV = 8'b0010_0000,
        S_EMIT = 8'b0100_0000,
        S_ONE  = 8'b1000_0000
    } t_state;

    t_state           r_state, n_state;
    t_plan            r_plan, n_plan, dec;
    logic             accept;
    logic             has_arg;
    logic [LEN_W-1:0] alen;
    logic [15:0]      nm;

    // command decode from the first three characters and the line length
    always_comb begin
        dec     = '0;
        alen    = i_sts.run_len - LEN_W'(2);
        has_arg = (i_sts.run_len > LEN_W'(2));
        nm      = {i_sts.c0, i_sts.c1};
        if (i_sts.run_len < LEN_W'(2)) begin
            dec.reply = 1'b1;
            dec.tpl   = TPL_Q;
        end else begin
            case (nm)
                CMD_ID: begin
                    dec.reply = !has_arg;
                    dec.tpl   = TPL_ID;
                end
                CMD_PS: begin
                    dec.reply = !has_arg;
                    dec.tpl   = TPL_PS;
                end
                CMD_AI: begin
                    if (!has_arg) begin
                        dec.reply = 1'b1;
                        dec.tpl   = TPL_AI;
                        dec.vsrc  = VS_AIM;
                    end else begin
                        dec.aim_wr = (i_sts.a0 >= CH_0) && (i_sts.a0 <= CH_4);
                    end
                end
                CMD_FA: begin
                    if (!has_arg) begin
                        dec.reply = 1'b1;
                        dec.tpl   = TPL_F11;
                        dec.vsrc  = VS_FREQ;
                    end else if (alen == LEN_W'(11)) begin
                        dec.parse    = 1'b1;
                        dec.set      = 1'b1;
                        dec.ssrc     = SS_ACC;
                        dec.set_kind = SK_FREQ;
                    end
                end
                CMD_FB: begin
                    if (!has_arg) begin
                        dec.vfo_snap = i_sts.vfo_zero;
                        dec.reply    = 1'b1;
                        dec.tpl      = TPL_F11;
                        dec.vsrc     = VS_VFO;
                    end else if (alen == LEN_W'(11)) begin
                        dec.parse     = 1'b1;
                        dec.vfo_parse = 1'b1;
                    end
                end
                CMD_FR, CMD_FT: begin
                    dec.reply = !has_arg;
                    dec.tpl   = TPL_FR;
                end
                CMD_MD: begin
                    if (!has_arg) begin
                        dec.reply = 1'b1;
                        dec.tpl   = TPL_MD;
                    end else if ((i_sts.a0 >= CH_1) && (i_sts.a0 <= CH_5)) begin
                        dec.cw_wr    = 1'b1;
                        dec.set      = 1'b1;
                        dec.ssrc     = SS_MODE;
                        dec.set_kind = SK_MODE;
                    end
                end
                CMD_SM: begin
                    dec.reply = 1'b1;
                    dec.tpl   = has_arg ? TPL_SMA : TPL_SM;
                    dec.vsrc  = VS_METER;
                end
                CMD_AG: begin
                    if (alen <= LEN_W'(1)) begin
                        dec.reply = 1'b1;
                        dec.tpl   = has_arg ? TPL_AGA : TPL_AG;
                        dec.vsrc  = VS_AGV;
                    end else if ((alen == LEN_W'(3)) || (alen == LEN_W'(4))) begin
                        dec.parse    = 1'b1;
                        dec.pstart3  = (alen == LEN_W'(4));
                        dec.set      = 1'b1;
                        dec.ssrc     = SS_AG;
                        dec.set_kind = SK_VOL;
                    end
                end
                CMD_SQ: begin
                    dec.reply = (alen <= LEN_W'(1));
                    dec.tpl   = TPL_SQ;
                end
                CMD_MU: begin
                    if (!has_arg) begin
                        dec.reply = 1'b1;
                        dec.tpl   = TPL_MU;
                    end else if ((i_sts.a0 == CH_0) || (i_sts.a0 == CH_1)) begin
                        dec.set      = 1'b1;
                        dec.ssrc     = SS_MUTE;
                        dec.set_kind = SK_MUTE;
                    end
                end
                CMD_IF: begin
                    dec.reply = !has_arg;
                    dec.tpl   = TPL_IF;
                    dec.vsrc  = VS_FREQ;
                end
                CMD_ZZ: begin
                    dec.reply = 1'b1;
                    dec.tpl   = TPL_Q;
                end
                CMD_RX: begin
                    dec.reply = 1'b0;
                end
                CMD_TX: begin
                    dec.reply = 1'b1;
                    dec.tpl   = TPL_N;
                end
                default: begin
                    dec.reply = !has_arg;
                    dec.tpl   = TPL_Q;
                end
            endcase
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state    = r_state;
        n_plan     = r_plan;
        o_cmd      = '0;
        o_cmd.plan = (r_state == S_EXEC) ? dec : r_plan;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_in_cmd) begin
                        o_cmd.snap_ld = 1'b1;
                    end else begin
                        case (i_sts.cls)
                            CLS_SEMI: begin
                                if (i_sts.discarding) begin
                                    o_cmd.disc_clr = 1'b1;
                                end else if (!i_sts.len_zero) begin
                                    o_cmd.run_start = 1'b1;
                                    n_state         = S_EXEC;
                                end
                            end
                            CLS_LEGAL: begin
                                if (!i_sts.discarding) begin
                                    if (i_sts.len_full) begin
                                        o_cmd.drop_line = 1'b1;
                                        o_cmd.pos_clr   = 1'b1;
                                        n_plan          = '0;
                                        n_plan.reply    = 1'b1;
                                        n_plan.tpl      = TPL_O;
                                        n_state         = S_EMIT;
                                    end else begin
                                        o_cmd.buf_wr = 1'b1;
                                    end
                                end
                            end
                            CLS_ILLEGAL: begin
                                if (!i_sts.discarding) begin
                                    o_cmd.drop_line = 1'b1;
                                    n_plan          = '0;
                                    n_plan.drop     = 1'b1;
                                    n_state         = S_ONE;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
            S_EXEC: begin
                n_plan           = dec;
                o_cmd.aim_wr     = dec.aim_wr;
                o_cmd.vfo_snap   = dec.vfo_snap;
                o_cmd.cw_wr      = dec.cw_wr;
                o_cmd.pos_clr    = 1'b1;
                o_cmd.parse_init = 1'b1;
                if (dec.parse) begin
                    n_state = S_PRD;
                end else if (dec.set || (dec.reply && (dec.vsrc != VS_NONE))) begin
                    n_state = S_CALC;
                end else if (dec.reply) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_PRD: begin
                o_cmd.parse_rd = 1'b1;
                n_state        = S_PACC;
            end
            S_PACC: begin
                o_cmd.parse_acc = i_sts.rd_digit;
                n_state = (!i_sts.rd_digit || i_sts.parse_end) ? S_CALC : S_PRD;
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
                if (r_plan.reply) begin
                    n_state = S_CONV;
                end else if (r_plan.set) begin
                    n_state = S_ONE;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_CONV: begin
                o_cmd.conv_step = 1'b1;
                if (i_sts.conv_last) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_tpl = 1'b1;
                    if (i_sts.emit_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_ONE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_one = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_plan  <= '0;
        end else begin
            r_state <= n_state;
            r_plan  <= n_plan;
        end
    end
endmodule

// ===== rtl/cci_dp.sv =====
module cci_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [7:0]        i_rx_byte,
    input  logic [31:0]       i_freq_hz,
    input  logic [1:0]        i_radio_mode,
    input  logic [5:0]        i_volume,
    input  logic signed [7:0] i_rssi_dbuv,
    input  logic              i_muted,
    input  cci_pkg::t_dp_cmd  i_cmd,
    output cci_pkg::t_dp_sts  o_sts,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [1:0]        o_kind,
    output logic [7:0]        o_out_byte,
    output logic [1:0]        o_set_kind,
    output logic [31:0]       o_set_value,
    output logic              o_last
);
    import cci_pkg::*;

    // radio snapshot and command state
    logic [31:0]       r_snap_freq;
    logic [1:0]        r_snap_mode;
    logic [5:0]        r_snap_vol;
    logic signed [7:0] r_snap_rssi;
    logic              r_snap_muted;
    logic [31:0]       r_vfo;
    logic [2:0]        r_aim;
    logic              r_cw;

    // line assembly
    logic [LEN_W-1:0]  r_len;
    logic              r_disc;
    logic [7:0]        r_c0, r_c1, r_a0;
    logic [LEN_W-1:0]  r_run_len;

    // argument parser
    logic [LEN_W-1:0]  r_ptr;
    logic [31:0]       r_acc;
    logic [7:0]        rd_data;

    // converter and emitter
    logic [VAL_W-1:0]  r_bin;
    logic [BCD_W-1:0]  r_bcd;
    logic [CNT_W-1:0]  r_cnt;
    logic [POS_W-1:0]  r_pos;
    logic [31:0]       r_setv;

    // output register
    logic              r_ovalid;
    logic [1:0]        r_kind;
    logic [7:0]        r_byte;
    logic [1:0]        r_skind;
    logic [31:0]       r_sval;
    logic              r_last;

    t_cls              cls;
    logic              out_free;
    logic [35:0]       acc10;
    logic [31:0]       acc_nxt;
    logic signed [9:0] mt;
    logic [5:0]        meter;
    logic [13:0]       ag_x;
    logic [28:0]       ag_p;
    logic [7:0]        sv8;
    logic [13:0]       sv_y;
    logic [30:0]       sv_p;
    logic [31:0]       bin_ld;
    logic [31:0]       setv_ld;
    logic [BCD_W-1:0]  bcd_adj;
    logic [POS_W-1:0]  t_len;
    logic [POS_W-1:0]  bidx;
    logic [8*TPL_MAX-1:0] text;
    logic [7:0]        sym;
    logic [3:0]        dig;
    logic [3:0]        bcd_d;
    logic [7:0]        mode_ch;
    logic [7:0]        emit_byte;

    cci_ram #(.WIDTH(8), .DEPTH(LINE_MAX)) u_line (
        .i_clk   (i_clk),
        .i_we    (i_cmd.buf_wr),
        .i_waddr (r_len[ADDR_W-1:0]),
        .i_wdata (i_rx_byte),
        .i_raddr (r_ptr[ADDR_W-1:0]),
        .o_rdata (rd_data)
    );

    always_comb begin
        if ((i_rx_byte == CH_CR) || (i_rx_byte == CH_LF)) begin
            cls = CLS_SKIP;
        end else if (i_rx_byte == CH_SEMI) begin
            cls = CLS_SEMI;
        end else if (((i_rx_byte >= CH_A) && (i_rx_byte <= CH_Z)) ||
                     ((i_rx_byte >= CH_0) && (i_rx_byte <= CH_9)) ||
                     (i_rx_byte == CH_PLUS) || (i_rx_byte == CH_MINUS)) begin
            cls = CLS_LEGAL;
        end else begin
            cls = CLS_ILLEGAL;
        end
    end

    // decimal accumulate with saturation at 2^32-1
    always_comb begin
        acc10   = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0} + {32'd0, rd_data[3:0]};
        acc_nxt = (acc10[35:32] != 4'd0) ? 32'hFFFF_FFFF : acc10[31:0];
    end

    // value into the converter and value of a set request
    always_comb begin
        mt    = {{2{r_snap_rssi[7]}}, r_snap_rssi} + 10'sd20;
        if (mt <= 10'sd0) begin
            meter = 6'd0;
        end else if (mt[7:2] > 6'd30) begin
            meter = 6'd30;
        end else begin
            meter = mt[7:2];
        end
        ag_x  = {r_snap_vol, 8'd0} - {8'd0, r_snap_vol} + 14'd31;
        ag_p  = ag_x * AG_RECIP;
        sv8   = (r_acc > 32'd255) ? 8'hFF : r_acc[7:0];
        sv_y  = {sv8, 6'd0} - {6'd0, sv8} + 14'd127;
        sv_p  = sv_y * SET_RECIP;

        case (i_cmd.plan.vsrc)
            VS_AIM:   bin_ld = {29'd0, r_aim};
            VS_FREQ:  bin_ld = r_snap_freq;
            VS_VFO:   bin_ld = r_vfo;
            VS_METER: bin_ld = {26'd0, meter};
            VS_AGV:   bin_ld = {24'd0, ag_p[27:20]};
            default:  bin_ld = 32'd0;
        endcase

        case (i_cmd.plan.ssrc)
            SS_ACC: setv_ld = r_acc;
            SS_MODE: begin
                case (r_a0)
                    CH_1:       setv_ld = 32'd1;
                    CH_2, CH_3: setv_ld = 32'd2;
                    CH_4:       setv_ld = 32'd0;
                    default:    setv_ld = 32'd3;
                endcase
            end
            SS_AG:   setv_ld = {26'd0, sv_p[29:24]};
            default: setv_ld = {31'd0, r_a0[0]};
        endcase
    end

    // double dabble: add 3 to every digit of five or more, then shift
    always_comb begin
        for (int i = 0; i < BCD_DIGITS; i++) begin
            bcd_adj[4*i +: 4] = (r_bcd[4*i +: 4] >= 4'd5) ? r_bcd[4*i +: 4] + 4'd3
                                                          : r_bcd[4*i +: 4];
        end
    end

    // template symbol at the current position
    always_comb begin
        t_len = tpl_len(i_cmd.plan.tpl);
        text  = tpl_text(i_cmd.plan.tpl);
        bidx  = t_len - POS_W'(1) - r_pos;
        sym   = text[{bidx, 3'b000} +: 8];
        dig   = 4'(sym - PH_DIG0);
        bcd_d = r_bcd[{dig, 2'b00} +: 4];
        case (r_snap_mode)
            2'd1:    mode_ch = CH_1;
            2'd2:    mode_ch = r_cw ? CH_3 : CH_2;
            2'd0:    mode_ch = CH_4;
            default: mode_ch = CH_5;
        endcase
        if ((sym >= PH_DIG0) && (sym <= PH_DIG10)) begin
            emit_byte = CH_0 + {4'd0, bcd_d};
        end else begin
            case (sym)
                PH_C0:   emit_byte = r_c0;
                PH_C1:   emit_byte = r_c1;
                PH_A0:   emit_byte = r_a0;
                PH_MODE: emit_byte = mode_ch;
                PH_MUTE: emit_byte = r_snap_muted ? CH_1 : CH_0;
                default: emit_byte = sym;
            endcase
        end
    end

    assign out_free = !r_ovalid || i_ready;

    always_comb begin
        o_sts.cls        = cls;
        o_sts.discarding = r_disc;
        o_sts.len_zero   = (r_len == LEN_W'(0));
        o_sts.len_full   = (r_len >= LEN_W'(LINE_MAX));
        o_sts.c0         = r_c0;
        o_sts.c1         = r_c1;
        o_sts.a0         = r_a0;
        o_sts.run_len    = r_run_len;
        o_sts.vfo_zero   = (r_vfo == 32'd0);
        o_sts.rd_digit   = (rd_data >= CH_0) && (rd_data <= CH_9);
        o_sts.parse_end  = (r_ptr == r_run_len);
        o_sts.conv_last  = (r_cnt == CNT_W'(CONV_STEPS - 1));
        o_sts.emit_last  = (r_pos == t_len - POS_W'(1));
        o_sts.out_free   = out_free;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_freq  <= '0;
            r_snap_mode  <= '0;
            r_snap_vol   <= '0;
            r_snap_rssi  <= '0;
            r_snap_muted <= 1'b0;
            r_vfo        <= '0;
            r_aim        <= '0;
            r_cw         <= 1'b0;
            r_len        <= '0;
            r_disc       <= 1'b0;
            r_ovalid     <= 1'b0;
        end else begin
            if (i_cmd.snap_ld) begin
                r_snap_freq  <= i_freq_hz;
                r_snap_mode  <= i_radio_mode;
                r_snap_vol   <= i_volume;
                r_snap_rssi  <= i_rssi_dbuv;
                r_snap_muted <= i_muted;
            end
            if (i_cmd.aim_wr) begin
                r_aim <= r_a0[2:0];
            end
            if (i_cmd.cw_wr) begin
                r_cw <= (r_a0 == CH_3);
            end
            if (i_cmd.vfo_snap) begin
                r_vfo <= r_snap_freq;
            end else if (i_cmd.calc && i_cmd.plan.vfo_parse) begin
                r_vfo <= r_acc;
            end
            if (i_cmd.buf_wr) begin
                r_len <= r_len + LEN_W'(1);
            end else if (i_cmd.drop_line || i_cmd.disc_clr || i_cmd.run_start) begin
                r_len <= '0;
            end
            if (i_cmd.drop_line) begin
                r_disc <= 1'b1;
            end else if (i_cmd.disc_clr) begin
                r_disc <= 1'b0;
            end
            if (i_cmd.emit_tpl || i_cmd.emit_one) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.buf_wr) begin
            if (r_len == LEN_W'(0)) r_c0 <= i_rx_byte;
            if (r_len == LEN_W'(1)) r_c1 <= i_rx_byte;
            if (r_len == LEN_W'(2)) r_a0 <= i_rx_byte;
        end
        if (i_cmd.run_start) begin
            r_run_len <= r_len;
        end
        if (i_cmd.parse_init) begin
            r_ptr <= i_cmd.plan.pstart3 ? LEN_W'(3) : LEN_W'(2);
            r_acc <= '0;
        end else begin
            if (i_cmd.parse_rd) begin
                r_ptr <= r_ptr + LEN_W'(1);
            end
            if (i_cmd.parse_acc) begin
                r_acc <= acc_nxt;
            end
        end
        if (i_cmd.calc) begin
            r_bin  <= bin_ld;
            r_bcd  <= '0;
            r_cnt  <= '0;
            r_setv <= setv_ld;
        end else if (i_cmd.conv_step) begin
            r_bcd <= {bcd_adj[BCD_W-2:0], r_bin[VAL_W-1]};
            r_bin <= {r_bin[VAL_W-2:0], 1'b0};
            r_cnt <= r_cnt + CNT_W'(1);
        end
        if (i_cmd.pos_clr) begin
            r_pos <= '0;
        end else if (i_cmd.emit_tpl) begin
            r_pos <= r_pos + POS_W'(1);
        end
        if (i_cmd.emit_tpl) begin
            r_kind  <= KIND_BYTE;
            r_byte  <= emit_byte;
            r_skind <= 2'd0;
            r_sval  <= 32'd0;
            r_last  <= (r_pos == t_len - POS_W'(1));
        end else if (i_cmd.emit_one) begin
            r_kind  <= i_cmd.plan.drop ? KIND_DROP : KIND_SET;
            r_byte  <= 8'd0;
            r_skind <= i_cmd.plan.drop ? 2'd0 : i_cmd.plan.set_kind;
            r_sval  <= i_cmd.plan.drop ? 32'd0 : r_setv;
            r_last  <= 1'b1;
        end
    end

    assign o_valid     = r_ovalid;
    assign o_kind      = r_kind;
    assign o_out_byte  = r_byte;
    assign o_set_kind  = r_skind;
    assign o_set_value = r_sval;
    assign o_last      = r_last;
endmodule

// ===== rtl/cat_command_interpreter.sv =====
// Channel  Dir  Payload                                          Handshake
// i_in     in   cmd, rx_byte, freq_hz, radio_mode, volume,       valid/ready
//               rssi_dbuv, muted
// o_out    out  kind, out_byte, set_kind, set_value, last        valid/ready
//
// A status update, a buffered byte or an ignored byte is taken while idle.
// A ';' runs the line: a decode state, then a read and an accumulate state per
// argument digit read back from the line RAM, a calc state when a number or set
// value is needed, binary to BCD conversion when the reply carries a number, and
// the reply bytes one after another while o_out is not stalled (up to 38 for IF).
// Reset (i_rst_n low, synchronous) empties the line, ends discard and zeroes
// the radio snapshot, VFO B, auto-info mode and CW flag. No clearing pass.
// A stalled o_out holds the emitter; the result register lets the next
// request in once the last result of a line is loaded.
module cat_command_interpreter (
    input logic      i_clk,
    input logic      i_rst_n,
    cci_in_if.sink   i_in,
    cci_out_if.source o_out
);
    import cci_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic    w_in_ready;

    // sequencer: byte handling, command decode, parse / convert / emit steps
    cci_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_cmd   (i_in.cmd),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // line RAM, snapshot, parser, BCD converter and result register
    cci_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rx_byte    (i_in.rx_byte),
        .i_freq_hz    (i_in.freq_hz),
        .i_radio_mode (i_in.radio_mode),
        .i_volume     (i_in.volume),
        .i_rssi_dbuv  (i_in.rssi_dbuv),
        .i_muted      (i_in.muted),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .o_valid      (o_out.valid),
        .i_ready      (o_out.ready),
        .o_kind       (o_out.kind),
        .o_out_byte   (o_out.out_byte),
        .o_set_kind   (o_out.set_kind),
        .o_set_value  (o_out.set_value),
        .o_last       (o_out.last)
    );

    assign i_in.ready = w_in_ready;

    // no request is taken while a result is being loaded
    a_no_accept_on_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.emit_tpl || w_cmd.emit_one) |-> !w_in_ready)
        else $error("request accepted while emitting");

    // the line buffer is never written past its end
    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.buf_wr |-> !w_sts.len_full)
        else $error("line buffer overfilled");

    // set requests and drops are single results
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.kind != KIND_BYTE)) |-> o_out.last)
        else $error("set or drop without last");

    // a run of a line starts only from a non-empty buffer
    a_run_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.run_start |=> (w_sts.run_len != '0))
        else $error("empty line run");
endmodule

// ===== verif/tb_cat_command_interpreter.sv =====
module tb_cat_command_interpreter;
    import cci_pkg::*;

    typedef struct {
        logic [1:0]  kind;
        logic [7:0]  out_byte;
        logic [1:0]  set_kind;
        logic [31:0] set_value;
        logic        last;
    } t_reply;

    // Scoreboard: tracks the CAT line state and queues the expected replies.
    class cat_scoreboard;
        logic [7:0]  line_q[$];
        bit          discarding;
        logic [2:0]  ai_mode;
        bit          cw_flag;
        logic [31:0] vfo_b;
        logic [31:0] s_freq;
        logic [1:0]  s_mode;
        logic [5:0]  s_vol;
        logic [7:0]  s_rssi;
        bit          s_mute;
        t_reply      pending_q[$];
        t_reply      step_q[$];
        int          n_err;
        int          n_seen;

        function void clear();
            line_q.delete(); discarding = 0; ai_mode = 0; cw_flag = 0;
            vfo_b = 0; s_freq = 0; s_mode = 0; s_vol = 0; s_rssi = 0; s_mute = 0;
        endfunction

        function void put(logic [1:0] k, logic [7:0] b, logic [1:0] sk, logic [31:0] sv);
            t_reply r;
            r.kind = k; r.out_byte = b; r.set_kind = sk; r.set_value = sv; r.last = 0;
            step_q.push_back(r);
        endfunction

        function void put_str(string s);
            for (int i = 0; i < s.len(); i++) put(KIND_BYTE, s[i], 0, 0);
        endfunction

        function void put_dec(logic [31:0] v, int digits);
            logic [7:0] d[12];
            for (int i = digits - 1; i >= 0; i--) begin
                d[i] = 8'(CH_0 + v % 10); v = v / 10;
            end
            for (int i = 0; i < digits; i++) put(KIND_BYTE, d[i], 0, 0);
        endfunction

        function logic [31:0] read_num(int from);
            logic [63:0] v;
            v = 0;
            for (int i = from; i < line_q.size(); i++) begin
                if (line_q[i] < CH_0 || line_q[i] > CH_9) break;
                v = v * 10 + (line_q[i] - CH_0);
                if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF;
            end
            return v[31:0];
        endfunction

        function logic [7:0] mode_char();
            case (s_mode)
                2'd1: return CH_1;
                2'd2: return cw_flag ? CH_3 : CH_2;
                2'd0: return CH_4;
                default: return CH_5;
            endcase
        endfunction

        function void run_cmd();
            int len, alen, t, meter;
            logic [7:0] a0;
            logic [15:0] c;
            logic [31:0] v;
            logic [1:0] m;
            len = line_q.size();
            if (len < 2) begin put_str("?;"); return; end
            alen = len - 2;
            a0 = alen ? line_q[2] : 8'h00;
            c = {line_q[0], line_q[1]};
            case (c)
                CMD_ID: if (!alen) put_str("ID020;");
                CMD_PS: if (!alen) put_str("PS1;");
                CMD_AI: begin
                    if (!alen) begin put_str("AI"); put_dec(ai_mode, 1); put_str(";"); end
                    else if (a0 >= CH_0 && a0 <= CH_4) ai_mode = 3'(a0 - CH_0);
                end
                CMD_FA: begin
                    if (!alen) begin put_str("FA"); put_dec(s_freq, 11); put_str(";"); end
                    else if (alen == 11) put(KIND_SET, 0, SK_FREQ, read_num(2));
                end
                CMD_FB: begin
                    if (!alen) begin
                        if (vfo_b == 0) vfo_b = s_freq;
                        put_str("FB"); put_dec(vfo_b, 11); put_str(";");
                    end else if (alen == 11) vfo_b = read_num(2);
                end
                CMD_FR, CMD_FT: if (!alen) begin
                    put(KIND_BYTE, line_q[0], 0, 0); put(KIND_BYTE, line_q[1], 0, 0);
                    put_str("0;");
                end
                CMD_MD: begin
                    if (!alen) begin
                        put_str("MD"); put(KIND_BYTE, mode_char(), 0, 0); put_str(";");
                    end else if (a0 >= CH_1 && a0 <= CH_5) begin
                        case (a0)
                            CH_1: m = 1;
                            CH_2, CH_3: m = 2;
                            CH_4: m = 0;
                            default: m = 3;
                        endcase
                        cw_flag = (a0 == CH_3);
                        put(KIND_SET, 0, SK_MODE, m);
                    end
                end
                CMD_SM: begin
                    t = $signed(s_rssi) + 20;
                    meter = t <= 0 ? 0 : t / 4;
                    if (meter > 30) meter = 30;
                    put_str("SM");
                    if (alen >= 1) put(KIND_BYTE, a0, 0, 0);
                    put_dec(meter, 4); put_str(";");
                end
                CMD_AG: begin
                    if (alen <= 1) begin
                        put_str("AG");
                        if (alen == 1) put(KIND_BYTE, a0, 0, 0);
                        put_dec((s_vol * 255 + 31) / 63, 3); put_str(";");
                    end else if (alen == 3 || alen == 4) begin
                        v = read_num(alen == 4 ? 3 : 2);
                        if (v > 255) v = 255;
                        put(KIND_SET, 0, SK_VOL, (v * 63 + 127) / 255);
                    end
                end
                CMD_SQ: if (alen <= 1) put_str("SQ0000;");
                CMD_MU: begin
                    if (!alen) put_str(s_mute ? "MU1;" : "MU0;");
                    else if (a0 == CH_0 || a0 == CH_1) put(KIND_SET, 0, SK_MUTE, a0 == CH_1);
                end
                CMD_IF: if (!alen) begin
                    put_str("IF"); put_dec(s_freq, 11); put_str("0000+00000000000");
                    put(KIND_BYTE, mode_char(), 0, 0); put_str("0000000;");
                end
                CMD_ZZ: put_str("?;");
                CMD_RX: ;
                CMD_TX: put_str("N;");
                default: if (!alen) put_str("?;");
            endcase
        endfunction

        // Accepted request: update the shadow state and queue its replies.
        function void note_request(bit cmd, logic [7:0] b, logic [31:0] f, logic [1:0] md,
                                   logic [5:0] vol, logic [7:0] rs, bit mu);
            bit legal;
            step_q.delete();
            if (cmd) begin
                s_freq = f; s_mode = md; s_vol = vol; s_rssi = rs; s_mute = mu;
                return;
            end
            if (b == CH_CR || b == CH_LF) return;
            if (b == CH_SEMI) begin
                if (discarding) discarding = 0;
                else if (line_q.size() != 0) run_cmd();
                line_q.delete();
            end else if (!discarding) begin
                legal = (b >= CH_A && b <= CH_Z) || (b >= CH_0 && b <= CH_9) ||
                        b == CH_PLUS || b == CH_MINUS;
                if (!legal) begin
                    line_q.delete(); discarding = 1; put(KIND_DROP, 0, 0, 0);
                end else if (line_q.size() >= LINE_MAX) begin
                    line_q.delete(); discarding = 1; put_str("O;");
                end else line_q.push_back(b);
            end
            if (step_q.size() != 0) step_q[step_q.size() - 1].last = 1;
            foreach (step_q[i]) pending_q.push_back(step_q[i]);
        endfunction

        function void check_reply(t_reply got);
            t_reply e;
            n_seen++;
            if (pending_q.size() == 0) begin
                n_err++;
                $display("%0t: unexpected result kind=%0d byte=%h", $time, got.kind,
                         got.out_byte);
                return;
            end
            e = pending_q.pop_front();
            if (got.kind !== e.kind)
                $display("%0t: kind exp %0d got %0d", $time, e.kind, got.kind);
            if (got.out_byte !== e.out_byte)
                $display("%0t: out_byte exp %h got %h", $time, e.out_byte, got.out_byte);
            if (got.set_kind !== e.set_kind)
                $display("%0t: set_kind exp %0d got %0d", $time, e.set_kind, got.set_kind);
            if (got.set_value !== e.set_value)
                $display("%0t: set_value exp %h got %h", $time, e.set_value, got.set_value);
            if (got.last !== e.last)
                $display("%0t: last exp %b got %b", $time, e.last, got.last);
            if (got.kind !== e.kind || got.out_byte !== e.out_byte ||
                got.set_kind !== e.set_kind || got.set_value !== e.set_value ||
                got.last !== e.last) n_err++;
        endfunction
    endclass

    localparam int IDLE_LIMIT = 20000;

    logic i_clk;
    logic i_rst_n;
    cci_in_if  in_ch();
    cci_out_if out_ch();

    cat_command_interpreter u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    cat_scoreboard sb;
    int  idle_cycles;
    int  n_sent;
    int  hold_req;    // long receiver stalls requested by the stimulus
    bit  no_stall;    // receiver stall pattern off
    int  burst_left;
    logic [7:0] pend_b[$];   // byte queue for the request stream; never filled by the stimulus
    int  n_upd;

    always begin
        i_clk = 1'b0; #5;
        i_clk = 1'b1; #5;
    end

    // Receiver: own stall pattern, or a long counted hold-off.
    initial begin
        int hold_cnt;
        int hold_ack;
        hold_ack = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req != hold_ack) begin
                hold_cnt = 0;
                out_ch.ready <= 1'b0;
                while (hold_cnt < 400) begin @(posedge i_clk); hold_cnt++; end
                hold_ack = hold_req;
            end else if (no_stall) out_ch.ready <= 1'b1;
            else out_ch.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // Result monitor and watchdog.
    always @(posedge i_clk) begin
        t_reply r;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            r.kind = out_ch.kind; r.out_byte = out_ch.out_byte;
            r.set_kind = out_ch.set_kind; r.set_value = out_ch.set_value;
            r.last = out_ch.last;
            sb.check_reply(r);
        end
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: watchdog expired, %0d results still expected", $time,
                     sb.pending_q.size());
            $display("tb_cat_command_interpreter: errors");
            $finish;
        end
    end

    // Offer one request; sender sends in bursts with random gaps.
    task automatic send_request(bit cmd, logic [7:0] b, logic [31:0] f, logic [1:0] md,
                                logic [5:0] vol, logic [7:0] rs, bit mu);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        in_ch.valid <= 1'b1; in_ch.cmd <= cmd; in_ch.rx_byte <= b;
        in_ch.freq_hz <= f; in_ch.radio_mode <= md; in_ch.volume <= vol;
        in_ch.rssi_dbuv <= rs; in_ch.muted <= mu;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_request(cmd, b, f, md, vol, rs, mu);
        n_sent++;
    endtask

    task automatic send_byte(logic [7:0] b);
        send_request(0, b, $urandom, $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic send_line(string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    task automatic send_status(logic [31:0] f, logic [1:0] md, logic [5:0] vol,
                               logic [7:0] rs, bit mu);
        send_request(1, $urandom, f, md, vol, rs, mu);
        n_upd++;
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    function automatic string rand_digits(int n);
        string s;
        s = "";
        for (int i = 0; i < n; i++) s = {s, string'(8'(CH_0 + $urandom_range(0, 9)))};
        return s;
    endfunction

    function automatic string rand_line();
        string names[16];
        string s;
        int k;
        names = '{"ID", "PS", "AI", "FA", "FB", "FR", "FT", "MD", "SM", "AG", "SQ", "MU",
                  "IF", "RX", "TX", "ZZ"};
        s = names[$urandom_range(0, 15)];
        k = $urandom_range(0, 9);
        if (k < 4) ;
        else if (k < 6) s = {s, string'(8'(CH_0 + $urandom_range(0, 9)))};
        else if (k < 8) s = {s, rand_digits($urandom_range(2, 11))};
        else if (k == 8) s = {s, rand_digits(11)};
        else s = {s, (($urandom_range(0, 1)) ? "+" : "-"), rand_digits(2)};
        return {s, ";"};
    endfunction

    initial begin
        string s;
        int k;
        logic [7:0] b;
        sb = new();
        sb.clear();
        sb.n_err = 0; sb.n_seen = 0;
        n_sent = 0; n_upd = 0; burst_left = 0;
        hold_req = 0; no_stall = 0;
        in_ch.valid = 1'b0; in_ch.cmd = 1'b0; in_ch.rx_byte = 8'h00;
        in_ch.freq_hz = '0; in_ch.radio_mode = '0; in_ch.volume = '0;
        in_ch.rssi_dbuv = '0; in_ch.muted = 1'b0;
        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: queries on reset snapshot, extremes, each special case.
        send_line("IF;FB;");
        send_status(32'hFFFF_FFFF, 2'd2, 6'd63, 8'sd127, 1'b1);
        send_line("IF;SM;AG;MU;MD3;MD;");
        send_status(32'd0, 2'd3, 6'd0, 8'h80, 1'b0);
        send_line("SM1;FA99999999999;AG999;AG0255;\r\n;;A;");
        send_line("ZZ;XY;XY1;FA+0000000000;TX;RX;FR;FT;ID;PS;AI4;AI;SQ;MU1;MU0;");
        send_line("FB00000000123;FB;MD1;MD4;MD5;MD9;");
        send_line("AG#;Q;");   // drop, then ';' ends discard and Q runs as a short line
        drain();
        // Over-long line while the receiver holds off; block must back up.
        no_stall = 1;
        hold_req++;
        send_line("IF;IF;IF;");
        for (int i = 0; i < 33; i++) send_byte(CH_A);
        send_line("ZZZ;ID;");
        drain();
        no_stall = 0;

        // Random: mostly well-formed lines with random snapshot updates.
        while (n_sent < 280) begin
            k = $urandom_range(0, 19);
            if (k < 3)
                send_status($urandom_range(0, 3) == 0 ? 32'hFFFF_FFFF : $urandom,
                            $urandom, $urandom, $urandom, $urandom);
            else if (k < 16) send_line(rand_line());
            else if (k < 18) begin
                b = $urandom;
                send_byte(b);
            end else begin
                s = rand_line();
                send_line(s.substr(0, $urandom_range(0, s.len() - 2)));
                if ($urandom_range(0, 1)) send_byte($urandom);
                else send_byte(CH_SEMI);
            end
            if ($urandom_range(0, 40) == 0) no_stall = !no_stall;
        end
        drain();

        $display("sent %0d requests (%0d status updates), checked %0d results",
                 n_sent, n_upd, sb.n_seen);
        if (sb.n_err == 0 && sb.pending_q.size() == 0)
            $display("tb_cat_command_interpreter: clean");
        else
            $display("tb_cat_command_interpreter: errors");
        $finish;
    end
endmodule
